@@ design/lpfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CheckW = 2 * ByteW;
  localparam logic [ByteW:0] Modulus = 9'd255;

  // Packet phase, one-hot
  typedef enum logic [4:0] {
    PH_COMMAND = 5'b00001,
    PH_COUNT   = 5'b00010,
    PH_DATA    = 5'b00100,
    PH_CHK_HI  = 5'b01000,
    PH_CHK_LO  = 5'b10000
  } phase_t;

  // (a + b) mod 255 with a in 0..254, b in 0..255; the sum stays below 2 * 255
  function automatic logic [ByteW-1:0] add_mod255(input logic [ByteW-1:0] a,
                                                  input logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    logic [ByteW:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= Modulus) ? (s - Modulus) : s;
    return r[ByteW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/lens_packet_fletcher_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// rx        in         rx_valid / rx_stall  rx_byte[7:0]
// res       out        res_valid/res_stall  packet_command[7:0], computed_checksum[15:0],
//                                           checksum_ok
//
// One byte per cycle while no result waits under res_stall. A byte is captured into
// an input register; consuming it advances the phase, and for command, count and data
// bytes one modulo-255 add pair updates the running sums. Consuming the last checksum
// byte loads the result into the output register. Synchronous reset puts the block
// back to waiting for a command byte. While a result waits under res_stall, the held
// byte is not consumed and rx_stall rises as soon as the input register is full.
module lens_packet_fletcher_checker
  import lpfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_valid,
  output logic                   rx_stall,
  input  wire logic [ByteW-1:0]  rx_byte,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [ByteW-1:0]       packet_command,
  output logic [CheckW-1:0]      computed_checksum,
  output logic                   checksum_ok
);

  // Input register
  logic             in_vld;
  logic [ByteW-1:0] in_byte;

  // Packet state
  phase_t           phase, phase_next;
  logic [ByteW-1:0] data_remaining, data_remaining_next;
  logic [ByteW-1:0] low_sum, low_sum_next;
  logic [ByteW-1:0] high_sum, high_sum_next;
  logic [ByteW-1:0] held_command, held_command_next;
  logic [ByteW-1:0] received_check_high, received_check_high_next;

  logic             process;
  logic             rx_accept;
  logic             emit;
  logic [ByteW-1:0] sum_base;
  logic [ByteW-1:0] low_added;
  logic [ByteW-1:0] high_added;
  logic [ByteW-1:0] count_data;
  logic [CheckW-1:0] calc;

  // The held byte is consumed unless the output register is full and stalled
  assign process   = in_vld && !(res_valid && res_stall);
  assign rx_stall  = in_vld && !process;
  assign rx_accept = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (rx_accept) begin
      in_vld <= 1'b1;
    end else if (process) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) begin
      in_byte <= rx_byte;
    end
  end

  // Fletcher sums; a command byte restarts them from zero
  assign sum_base   = (phase == PH_COUNT || phase == PH_DATA) ? low_sum : '0;
  assign low_added  = add_mod255(sum_base, in_byte);
  assign high_added = add_mod255((phase == PH_COUNT || phase == PH_DATA) ? high_sum : '0,
                                 low_added);
  assign count_data = (in_byte < ByteW'(2)) ? '0 : in_byte - ByteW'(2);
  assign calc       = {high_sum, low_sum};

  // Phase sequencing
  always_comb begin
    phase_next               = phase;
    data_remaining_next      = data_remaining;
    low_sum_next             = low_sum;
    high_sum_next            = high_sum;
    held_command_next        = held_command;
    received_check_high_next = received_check_high;
    emit                     = 1'b0;
    case (phase)
      PH_COUNT: begin
        low_sum_next        = low_added;
        high_sum_next       = high_added;
        data_remaining_next = count_data;
        phase_next          = (count_data == '0) ? PH_CHK_HI : PH_DATA;
      end
      PH_DATA: begin
        low_sum_next        = low_added;
        high_sum_next       = high_added;
        data_remaining_next = data_remaining - ByteW'(1);
        if (data_remaining == ByteW'(1)) begin
          phase_next = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        received_check_high_next = in_byte;
        phase_next               = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        emit       = 1'b1;
        phase_next = PH_COMMAND;
      end
      default: begin
        held_command_next   = in_byte;
        low_sum_next        = low_added;
        high_sum_next       = high_added;
        data_remaining_next = '0;
        phase_next          = PH_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_COMMAND;
      data_remaining      <= '0;
      low_sum             <= '0;
      high_sum            <= '0;
      held_command        <= '0;
      received_check_high <= '0;
    end else if (process) begin
      phase               <= phase_next;
      data_remaining      <= data_remaining_next;
      low_sum             <= low_sum_next;
      high_sum            <= high_sum_next;
      held_command        <= held_command_next;
      received_check_high <= received_check_high_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (process && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      packet_command    <= held_command;
      computed_checksum <= calc;
      checksum_ok       <= ({received_check_high, in_byte} == calc);
    end
  end

endmodule

`default_nettype wire
